[hdl/buss_pkg.sv]
// shared types and constants for the bounded unique set store
// no dependencies; imported by buss_cell and bounded_unique_set_store_core
package buss_pkg;

	localparam int VALUE_W  = 32;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// link between neighbouring cells: sweep token and match-seen flag
	typedef struct packed {
		logic tok;
		logic fnd;
	} link_t;

endpackage

[hdl/buss_cell.sv]
// one storage cell of the set store chain: value register, local compare,
// delete shift from the upper neighbour, insert write; uses buss_pkg
module buss_cell import buss_pkg::*; #(
	parameter int CNT_W = 5,
	parameter int INDEX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  link_t                     link_in,
	output link_t                     link_out,
	input  logic signed [VALUE_W-1:0] key,
	input  logic                      del,
	input  logic                      ins_wr,
	input  logic        [CNT_W-1:0]   count,
	input  logic signed [VALUE_W-1:0] next_val,
	output logic signed [VALUE_W-1:0] val
);

	logic signed [VALUE_W-1:0] val_q;
	link_t                     link_q;
	logic                      live;
	logic                      hit;
	logic                      fnd_here;

	assign live     = CNT_W'(INDEX) < count;
	assign hit      = link_in.tok && live && (val_q == key);
	assign fnd_here = link_in.fnd || hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.tok <= link_in.tok;
			link_q.fnd <= link_in.tok && fnd_here;
		end
	end

	// at or above the deleted entry: pull the neighbour's value down
	always_ff @(posedge clk) begin
		if (link_in.tok && del && fnd_here) begin
			val_q <= next_val;
		end else if (ins_wr && (count == CNT_W'(INDEX))) begin
			val_q <= key;
		end
	end

	assign link_out = link_q;
	assign val      = val_q;

endmodule

[hdl/bounded_unique_set_store_core.sv]
// bounded unique set store: a start transfer sets launch_q, then the sweep token passes
// each cell's link register; done is registered from the token that leaves the last cell
// one item at a time; busy falls with the strobe, and no new item is taken while busy
// the sweep token walks the cell chain one cell per cycle
// reset clears the element count, busy and the strobe; stored values stay undefined
// the receiver cannot stall: each done strobe is shown for exactly one cycle
// depends on buss_pkg and buss_cell
module bounded_unique_set_store_core import buss_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic        [CMD_W-1:0]    cmd,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       done,
	output logic        [STATUS_W-1:0] status,
	output logic        [COUNT_W-1:0]  count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// command register and sweep launch
	logic                      accept;
	logic                      busy_q;
	logic                      launch_q;
	logic        [CMD_W-1:0]   cmd_q;
	logic signed [VALUE_W-1:0] key_q;

	// element count and result registers
	logic [CNT_W-1:0]    count_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;

	// chain wiring: link i feeds cell i, link CAPACITY leaves the last cell
	link_t                     chain [CAPACITY+1];
	logic signed [VALUE_W-1:0] vals  [CAPACITY];
	logic        [CAPACITY:0]  tok_vec;

	// end-of-sweep decision
	logic                finish;
	logic                found;
	logic                full;
	logic                del;
	logic                ins_wr;
	logic [STATUS_W-1:0] status_nxt;
	logic [CNT_W-1:0]    count_nxt;

	assign accept = start && !busy_q;

	// a command transfer latches the operands and launches the token into cell 0
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
		end else begin
			launch_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign chain[0] = '{tok: launch_q, fnd: 1'b0};
	assign del      = (cmd_q == CMD_DELETE);

	// row of cells; the top cell has no upper neighbour and refills from itself
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] nbr;

		if (i == CAPACITY - 1) begin : g_top
			assign nbr = vals[i];
		end else begin : g_mid
			assign nbr = vals[i+1];
		end

		buss_cell #(
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.link_in  (chain[i]),
			.link_out (chain[i+1]),
			.key      (key_q),
			.del      (del),
			.ins_wr   (ins_wr),
			.count    (count_q),
			.next_val (nbr),
			.val      (vals[i])
		);
	end

	for (genvar i = 0; i <= CAPACITY; i++) begin : g_tok
		assign tok_vec[i] = chain[i].tok;
	end

	// token leaving the last cell ends the sweep; its flag says whether any live cell matched
	assign finish = chain[CAPACITY].tok;
	assign found  = chain[CAPACITY].fnd;
	assign full   = (count_q >= CNT_W'(CAPACITY));

	always_comb begin
		status_nxt = ST_MISS;
		count_nxt  = count_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (found) begin
					status_nxt = ST_MISS;
				end else if (full) begin
					status_nxt = ST_FULL;
				end else begin
					status_nxt = ST_OK;
					count_nxt  = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (found) begin
					status_nxt = ST_OK;
					count_nxt  = count_q - CNT_W'(1);
				end else begin
					status_nxt = ST_MISS;
				end
			end
			// contains, and the unused code behaves the same
			default: begin
				status_nxt = found ? ST_OK : ST_MISS;
			end
		endcase
	end

	// insert writes the cell at the current fill position
	assign ins_wr = finish && (cmd_q == CMD_INSERT) && !found && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= finish;
			if (finish) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= status_nxt;
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign status = status_q;
	assign count  = COUNT_W'(count_q);

	// checks

	// only one sweep token is ever in flight; link 0 carries the launch itself
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one sweep token in the chain");

	// the fill count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	// a result strobe only follows a sweep that held busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result strobe without a command in progress");

	// a command transfer is always followed by busy and a launched token
	a_accept_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && launch_q))
		else $error("accepted command did not launch a sweep");

endmodule
